// ----- rtl/core/b64_pkg.sv -----
package b64_pkg;

    localparam int QueueDepth = 5;
    localparam int MaxResults = 4;

    localparam logic [7:0] CharPad = 8'h3D;

    localparam logic [1:0] RegDecodeMode = 2'd0;
    localparam logic [1:0] RegUrlSafe    = 2'd1;

    typedef struct packed {
        logic [17:0] bits;
        logic [1:0]  count;
        logic [1:0]  pads;
    } t_group;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_result;

    typedef struct packed {
        t_group                       nxt;
        t_result [MaxResults-1:0]     res;
        logic [2:0]                   nres;
    } t_step;

    // 6-bit value to alphabet character
    function automatic logic [7:0] sym(input logic [5:0] v, input logic url);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = 8'h41 + w;
        end else if (v < 6'd52) begin
            c = 8'h61 + w - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + w - 8'd52;
        end else if (v == 6'd62) begin
            c = url ? 8'h2D : 8'h2B;
        end else begin
            c = url ? 8'h5F : 8'h2F;
        end
        return c;
    endfunction

    // alphabet character to 6-bit value, unknown characters give zero
    function automatic logic [5:0] unsym(input logic [7:0] c, input logic url);
        logic [7:0] w;
        w = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            w = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            w = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            w = c - 8'h30 + 8'd52;
        end else if (url && c == 8'h2D) begin
            w = 8'd62;
        end else if (url && c == 8'h5F) begin
            w = 8'd63;
        end else if (!url && c == 8'h2B) begin
            w = 8'd62;
        end else if (!url && c == 8'h2F) begin
            w = 8'd63;
        end
        return w[5:0];
    endfunction

endpackage

// ----- rtl/core/b64_step.sv -----
module b64_step (
    input  b64_pkg::t_group i_grp,
    input  logic [7:0]      i_data_byte,
    input  logic            i_in_last,
    input  logic            i_decode_mode,
    input  logic            i_url_safe,
    output b64_pkg::t_step  o_step
);

    logic [1:0]  held;
    logic [23:0] x24;
    logic [15:0] x16;
    logic [17:0] x18;
    logic [11:0] x12;
    logic [5:0]  v;
    logic [1:0]  pads;
    logic [2:0]  total;
    logic [1:0]  avail;
    logic [1:0]  nbytes;
    logic [7:0]  bytes [3];

    assign held = (i_grp.count > 2'd2) ? 2'd2 : i_grp.count;
    assign v    = b64_pkg::unsym(i_data_byte, i_url_safe);
    assign pads = (i_data_byte == b64_pkg::CharPad && i_grp.pads < 2'd3) ? i_grp.pads + 2'd1
                                                                        : i_grp.pads;
    assign total = {1'b0, i_grp.count} + 3'd1;

    always_comb begin
        o_step = '0;
        o_step.nxt = '0;
        x24 = {i_grp.bits[15:0], i_data_byte};
        x16 = {i_grp.bits[7:0], i_data_byte};
        x18 = {i_grp.bits[11:0], v};
        x12 = {i_grp.bits[5:0], v};
        bytes[0] = 8'd0;
        bytes[1] = 8'd0;
        bytes[2] = 8'd0;
        avail  = 2'd0;
        nbytes = 2'd0;
        if (!i_decode_mode) begin
            if (held == 2'd2) begin
                o_step.res[0] = '{b64_pkg::sym(x24[23:18], i_url_safe), 1'b0, 1'b0};
                o_step.res[1] = '{b64_pkg::sym(x24[17:12], i_url_safe), 1'b0, 1'b0};
                o_step.res[2] = '{b64_pkg::sym(x24[11:6], i_url_safe), 1'b0, 1'b0};
                o_step.res[3] = '{b64_pkg::sym(x24[5:0], i_url_safe), i_in_last, 1'b0};
                o_step.nres   = 3'd4;
            end else if (!i_in_last) begin
                o_step.nxt.bits  = {i_grp.bits[9:0], i_data_byte};
                o_step.nxt.count = held + 2'd1;
                o_step.nxt.pads  = i_grp.pads;
            end else if (held == 2'd0) begin
                o_step.res[0] = '{b64_pkg::sym(i_data_byte[7:2], i_url_safe), 1'b0, 1'b0};
                o_step.res[1] = '{b64_pkg::sym({i_data_byte[1:0], 4'b0000}, i_url_safe),
                                  1'b0, 1'b0};
                o_step.res[2] = '{b64_pkg::CharPad, 1'b0, 1'b0};
                o_step.res[3] = '{b64_pkg::CharPad, 1'b1, 1'b0};
                o_step.nres   = 3'd4;
            end else begin
                o_step.res[0] = '{b64_pkg::sym(x16[15:10], i_url_safe), 1'b0, 1'b0};
                o_step.res[1] = '{b64_pkg::sym(x16[9:4], i_url_safe), 1'b0, 1'b0};
                o_step.res[2] = '{b64_pkg::sym({x16[3:0], 2'b00}, i_url_safe), 1'b0, 1'b0};
                o_step.res[3] = '{b64_pkg::CharPad, 1'b1, 1'b0};
                o_step.nres   = 3'd4;
            end
        end else begin
            if (total < 3'd4 && !i_in_last) begin
                o_step.nxt.bits  = {i_grp.bits[11:0], v};
                o_step.nxt.count = total[1:0];
                o_step.nxt.pads  = pads;
            end else if (total == 3'd1) begin
                o_step.res[0] = '{8'd0, 1'b1, 1'b1};
                o_step.nres   = 3'd1;
            end else begin
                if (total == 3'd4) begin
                    bytes[0] = i_grp.bits[17:10];
                    bytes[1] = {i_grp.bits[9:2]};
                    bytes[2] = {i_grp.bits[1:0], v};
                    avail    = 2'd3;
                end else if (total == 3'd3) begin
                    bytes[0] = x18[17:10];
                    bytes[1] = x18[9:2];
                    avail    = 2'd2;
                end else begin
                    bytes[0] = x12[11:4];
                    avail    = 2'd1;
                end
                nbytes = (pads >= avail) ? 2'd0 : avail - pads;
                if (nbytes == 2'd0) begin
                    if (i_in_last) begin
                        o_step.res[0] = '{8'd0, 1'b1, 1'b1};
                        o_step.nres   = 3'd1;
                    end
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        o_step.res[k] = '{bytes[k], i_in_last && (k + 1 == int'(nbytes)),
                                          1'b0};
                    end
                    o_step.nres = {1'b0, nbytes};
                end
            end
        end
    end

endmodule

// ----- rtl/core/base64_codec.sv -----
// Base64 encoder/decoder, standard or URL-safe alphabet.
// The results of an item are written into the registered result queue on its input transfer.
// Throughput: one input per cycle while at most one result is queued; an item
// giving n results puts n results into the queue (4 per 3 bytes when encoding).
// Reset (synchronous, active low) clears the configuration, the group and the result queue.
module base64_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_bad_length,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data
);

    logic             r_decode_mode;
    logic             r_url_safe;
    b64_pkg::t_group  r_grp;
    b64_pkg::t_step   step;
    b64_pkg::t_result r_q [b64_pkg::QueueDepth];
    b64_pkg::t_result n_q [b64_pkg::QueueDepth];
    logic [2:0]       r_cnt;
    logic [2:0]       n_cnt;
    logic [2:0]       base;
    logic             accept;
    logic             pop;

    b64_step u_step (
        .i_grp         (r_grp),
        .i_data_byte   (i_data_byte),
        .i_in_last     (i_in_last),
        .i_decode_mode (r_decode_mode),
        .i_url_safe    (r_url_safe),
        .o_step        (step)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = (r_cnt > 3'd1);
    assign accept       = i_in_valid && !o_in_stall;
    assign o_out_valid  = (r_cnt != 3'd0);
    assign pop          = o_out_valid && !i_out_stall;
    assign o_out_byte   = r_q[0].data;
    assign o_out_last   = r_q[0].last;
    assign o_bad_length = r_q[0].bad;

    always_comb begin
        n_q  = r_q;
        base = r_cnt;
        if (pop) begin
            for (int i = 0; i < b64_pkg::QueueDepth - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
            base = r_cnt - 3'd1;
        end
        n_cnt = base;
        if (accept) begin
            for (int k = 0; k < b64_pkg::MaxResults; k++) begin
                if (3'(k) < step.nres) begin
                    n_q[base + 3'(k)] = step.res[k];
                end
            end
            n_cnt = base + step.nres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_url_safe    <= 1'b0;
            r_grp         <= '0;
            r_cnt         <= 3'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    b64_pkg::RegDecodeMode: r_decode_mode <= i_cfg_data;
                    b64_pkg::RegUrlSafe:    r_url_safe    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_grp <= step.nxt;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(b64_pkg::QueueDepth))
        else $error("result queue overflow");

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_length) |-> o_out_last)
        else $error("length error on a result that does not end the message");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !pop) |=> (r_cnt >= $past(r_cnt)))
        else $error("queue lost results across a transfer");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_cnt == 3'd0))
        else $error("queue not empty after reset");

endmodule
